// ===== hw/rtl/swm_pkg.sv =====
`default_nettype none

package swm_pkg;

   // Window geometry
   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;

   // Cell index width, and a count that can hold WINDOW_MAX itself
   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   // Configuration register
   localparam int           CSR_W          = 7;
   localparam logic [CSR_W-1:0] WINDOW_RESET = CSR_W'(3);

   // Tdata width rounded up to whole bytes
   localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [IDX_W-1:0]        age_type;
   typedef logic [CNT_W-1:0]        count_type;

   // Control handed from the top level to the sorted row
   typedef struct packed {
      logic      push;   // word accepted this cycle
      logic      full;   // window already full before this word
      count_type fill;   // entries held before this word
      count_type win;    // effective window length, 1..WINDOW_MAX
   } row_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/swm_sort_row.sv =====
`default_nettype none

// Sorted register row. Each cell holds a sample and its age (0 = newest).
// One word per cycle while ctl.push is set: the cell whose age reaches
// the window length drops out, the row closes up over it, and the new
// sample is slotted in by a parallel compare against every cell.
module swm_sort_row (
   input  wire logic                clock,
   input  wire swm_pkg::row_ctl_type ctl,
   input  wire swm_pkg::sample_type  sample,
   output      swm_pkg::sample_type  median
);

   swm_pkg::sample_type key_ff [swm_pkg::WINDOW_MAX];
   swm_pkg::age_type    age_ff [swm_pkg::WINDOW_MAX];
   swm_pkg::sample_type key_in [swm_pkg::WINDOW_MAX];
   swm_pkg::age_type    age_in [swm_pkg::WINDOW_MAX];

   swm_pkg::sample_type cmp_key [swm_pkg::WINDOW_MAX];
   swm_pkg::age_type    cmp_age [swm_pkg::WINDOW_MAX];
   logic [swm_pkg::WINDOW_MAX-1:0] del;
   logic [swm_pkg::WINDOW_MAX-1:0] pdel;
   logic [swm_pkg::WINDOW_MAX-1:0] gt;
   logic [swm_pkg::WINDOW_MAX-1:0] msel;
   swm_pkg::count_type  n_after;
   swm_pkg::age_type    old_age;
   swm_pkg::count_type  mid;
   swm_pkg::sample_type med_acc;

   // Oldest entry has age win-1
   assign old_age = swm_pkg::IDX_W'(ctl.win - swm_pkg::CNT_W'(1));
   assign n_after = ctl.full ? (ctl.win - swm_pkg::CNT_W'(1)) : ctl.fill;
   assign mid     = (ctl.win - swm_pkg::CNT_W'(1)) >> 1;

   // Mark the leaving cell
   always_comb begin
      for (int i = 0; i < swm_pkg::WINDOW_MAX; i++) begin
         del[i] = ctl.full && (swm_pkg::CNT_W'(i) < ctl.fill) && (age_ff[i] == old_age);
      end
   end

   // Cells at or past the leaving one take their upper neighbour
   always_comb begin
      for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
         pdel[j] = |(del & ((swm_pkg::WINDOW_MAX)'(2) << j) - (swm_pkg::WINDOW_MAX)'(1));
      end
   end

   always_comb begin
      for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
         if (pdel[j] && (j < swm_pkg::WINDOW_MAX - 1)) begin
            cmp_key[j] = key_ff[(j < swm_pkg::WINDOW_MAX - 1) ? j + 1 : j];
            cmp_age[j] = age_ff[(j < swm_pkg::WINDOW_MAX - 1) ? j + 1 : j];
         end else begin
            cmp_key[j] = key_ff[j];
            cmp_age[j] = age_ff[j];
         end
         // empty cells count as above everything
         gt[j] = (swm_pkg::CNT_W'(j) >= n_after) || ($signed(cmp_key[j]) > $signed(sample));
      end
   end

   // Insert: below the slot keep, at the slot the new word, above it shift up
   always_comb begin
      for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
         if (!gt[j]) begin
            key_in[j] = cmp_key[j];
            age_in[j] = cmp_age[j] + swm_pkg::IDX_W'(1);
         end else if (j == 0 || !gt[(j > 0) ? j - 1 : 0]) begin
            key_in[j] = sample;
            age_in[j] = '0;
         end else begin
            key_in[j] = cmp_key[(j > 0) ? j - 1 : 0];
            age_in[j] = cmp_age[(j > 0) ? j - 1 : 0] + swm_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
            key_ff[j] <= key_in[j];
            age_ff[j] <= age_in[j];
         end
      end
   end

   // Lower median: cell (win-1)/2 of the updated row, as an and-or select
   always_comb begin
      med_acc = '0;
      for (int j = 0; j < swm_pkg::WINDOW_MAX; j++) begin
         msel[j] = (swm_pkg::CNT_W'(j) == mid);
         med_acc = med_acc | (key_in[j] & {swm_pkg::SAMPLE_WIDTH{msel[j]}});
      end
   end

   assign median = med_acc;

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_median.sv =====
`default_nettype none

// Channel   Dir  Handshake            Payload (lowest bit up)
// req       in   req_tvalid/tready    req_tdata: sample (signed)
// rsp       out  rsp_tvalid/tready    rsp_tdata: median (signed)
// csr       in   csr_wen              csr_wdata: window_size
//
// One word per cycle while the rsp side takes results; a result is offered
// in the cycle after the word that completes its window. The rate is set
// by the combinational delete/insert over the sorted register row.
// Reset is synchronous, active high; window_size returns to 3, row empty.
// A stalled result holds the input off until it is taken or leaves.
module sliding_window_median (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [swm_pkg::DATA_W-1:0] req_tdata,  // [31:0] sample
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [swm_pkg::DATA_W-1:0] rsp_tdata,  // [31:0] median
   input  wire logic                      csr_wen,
   input  wire logic [swm_pkg::CSR_W-1:0] csr_wdata   // [6:0] window_size
);

   logic [swm_pkg::CSR_W-1:0] win_cfg_ff;
   swm_pkg::count_type        fill_ff;
   swm_pkg::count_type        fill_in;
   swm_pkg::count_type        win;
   logic                      rsp_valid_ff;
   swm_pkg::sample_type       rsp_data_ff;
   swm_pkg::sample_type       median;
   swm_pkg::row_ctl_type      ctl;
   logic                      accept;
   logic                      full;
   logic                      emit;

   // Clamp window length into 1..WINDOW_MAX
   always_comb begin
      if (win_cfg_ff == '0) begin
         win = swm_pkg::CNT_W'(1);
      end else if (32'(win_cfg_ff) > swm_pkg::WINDOW_MAX) begin
         win = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
      end else begin
         win = swm_pkg::CNT_W'(win_cfg_ff);
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (fill_ff >= win);
   assign emit       = full || ((fill_ff + swm_pkg::CNT_W'(1)) >= win);
   assign fill_in    = full ? fill_ff : fill_ff + swm_pkg::CNT_W'(1);

   assign ctl.push = accept;
   assign ctl.full = full;
   assign ctl.fill = fill_ff;
   assign ctl.win  = win;

   swm_sort_row u_row (
      .clock  (clock),
      .ctl    (ctl),
      .sample (req_tdata[swm_pkg::SAMPLE_WIDTH-1:0]),
      .median (median)
   );

   // Config and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= swm_pkg::WINDOW_RESET;
         fill_ff    <= '0;
      end else if (csr_wen) begin
         win_cfg_ff <= csr_wdata;
         fill_ff    <= '0;
      end else if (accept) begin
         fill_ff    <= fill_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= median;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = swm_pkg::DATA_W'(rsp_data_ff);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 4;     // result is registered after its word
   localparam int TAIL_CYCLES   = 8;
   localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on any port
   localparam int RANDOM_WORDS  = 1400;
   localparam int HOLD_CYCLES   = 300;

   localparam swm_pkg::sample_type S_MAX = {1'b0, {(swm_pkg::SAMPLE_WIDTH-1){1'b1}}};
   localparam swm_pkg::sample_type S_MIN = {1'b1, {(swm_pkg::SAMPLE_WIDTH-1){1'b0}}};

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [swm_pkg::DATA_W-1:0]   req_tdata  = '0;   // [31:0] sample
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [swm_pkg::DATA_W-1:0]   rsp_tdata;         // [31:0] median
   logic                         csr_wen    = 1'b0;
   logic [swm_pkg::CSR_W-1:0]    csr_wdata  = '0;   // [6:0] window_size

   // predictor state
   swm_pkg::sample_type          arrivals [swm_pkg::WINDOW_MAX];
   swm_pkg::sample_type          sorted_row [swm_pkg::WINDOW_MAX];
   int                           fill_n;
   logic [swm_pkg::CSR_W-1:0]    win_reg;
   swm_pkg::sample_type          medians_due [$];

   int                  err_count = 0;
   int                  idle_run  = 0;
   bit                  tx_steady = 1'b0;
   bit                  rx_steady = 1'b0;
   int                  rsp_hold_cycles = 0;

   sliding_window_median u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------

   // effective window: 0 acts as 1, anything above the row length is clamped
   function automatic int window_len();
      int k;
      k = int'(win_reg);
      if (k < 1) k = 1;
      if (k > swm_pkg::WINDOW_MAX) k = swm_pkg::WINDOW_MAX;
      return k;
   endfunction

   // row holds n sorted entries; place s after any equal ones
   function automatic void row_insert(swm_pkg::sample_type s, int n);
      int i;
      i = n;
      while (i > 0 && $signed(sorted_row[i-1]) > $signed(s)) begin
         sorted_row[i] = sorted_row[i-1];
         i--;
      end
      sorted_row[i] = s;
   endfunction

   // drop exactly one copy of s from a row of n entries
   function automatic void row_remove(swm_pkg::sample_type s, int n);
      int i;
      i = 0;
      while (i < n && sorted_row[i] != s) i++;
      for (; i + 1 < n; i++) sorted_row[i] = sorted_row[i+1];
   endfunction

   function automatic void window_advance(swm_pkg::sample_type s);
      int                  k;
      swm_pkg::sample_type oldest;
      k = window_len();
      if (fill_n < k) begin
         for (int i = fill_n; i > 0; i--) arrivals[i] = arrivals[i-1];
         arrivals[0] = s;
         row_insert(s, fill_n);
         fill_n++;
         if (fill_n < k) return;
      end else begin
         oldest = arrivals[k-1];
         for (int i = k - 1; i > 0; i--) arrivals[i] = arrivals[i-1];
         arrivals[0] = s;
         row_remove(oldest, k);
         row_insert(s, k - 1);
      end
      // lower median: rank ceil(k/2)
      medians_due.push_back(sorted_row[(k-1)/2]);
   endfunction

   task automatic report_mismatch(input string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      err_count++;
   endtask

   // ---------------------------------------------------------------
   // Monitor: config and input words feed the predictor, results are checked
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         fill_n  = 0;
         win_reg = swm_pkg::WINDOW_RESET;
         medians_due.delete();
      end else begin
         if (csr_wen) begin
            win_reg = csr_wdata;
            fill_n  = 0;
         end
         if (req_tvalid && req_tready)
            window_advance(req_tdata[swm_pkg::SAMPLE_WIDTH-1:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (medians_due.size() == 0) begin
               report_mismatch($sformatf("median %0d with none due",
                                         $signed(rsp_tdata[swm_pkg::SAMPLE_WIDTH-1:0])));
            end else begin
               if (rsp_tdata[swm_pkg::SAMPLE_WIDTH-1:0] !== medians_due[0])
                  report_mismatch($sformatf("median got %0d expected %0d",
                                            $signed(rsp_tdata[swm_pkg::SAMPLE_WIDTH-1:0]),
                                            $signed(medians_due[0])));
               void'(medians_due.pop_front());
            end
         end
      end
   end

   // watchdog on cycles where no word moves anywhere
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_run <= 0;
      else
         idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
         $display("tb: timeout after %0d idle cycles", idle_run);
         $display("tb: errors");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, or a long hold when one is requested
   always begin
      int n;
      @(posedge clock);
      if (rsp_hold_cycles != 0) begin
         n = rsp_hold_cycles;
         rsp_hold_cycles = 0;
         rsp_tready <= 1'b0;
         repeat (n) @(posedge clock);
         rsp_tready <= 1'b1;
      end else begin
         n = rx_steady ? 0 : gap_len();
         if (n != 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers (entered and left at a rising edge)
   // ---------------------------------------------------------------
   task automatic put_sample(input swm_pkg::sample_type s);
      int g;
      g = tx_steady ? 0 : gap_len();
      if (g != 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= swm_pkg::DATA_W'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait until every due median is back and the row has settled;
   // first let the monitor log the last word
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (medians_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [swm_pkg::CSR_W-1:0] w);
      csr_wen   <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // extremes, a few small values to force duplicates, else full range
   function automatic swm_pkg::sample_type pick_sample();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (r < 4) begin
         v = $urandom_range(0, 16);
         v = v - 8;
         return swm_pkg::sample_type'(v);
      end
      return swm_pkg::sample_type'($urandom);
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // reset window of three: extremes, sign boundary, runs of equal values
   task automatic test_reset_window();
      swm_pkg::sample_type seq [12];
      seq = '{S_MAX, S_MIN, '0, '1, swm_pkg::sample_type'(1), S_MAX, S_MAX,
              S_MIN, S_MIN, S_MIN, swm_pkg::sample_type'(5), swm_pkg::sample_type'(5)};
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      foreach (seq[i]) put_sample(seq[i]);
      drain();
   endtask

   // window of zero behaves as one: every word is its own median
   task automatic test_zero_window();
      write_window('0);
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      put_sample(S_MIN);
      put_sample(S_MAX);
      put_sample('1);
      drain();
   endtask

   // rewrite part-way through filling: the window starts again from empty
   task automatic test_refill();
      write_window(swm_pkg::CSR_W'(5));
      put_sample(swm_pkg::sample_type'(100));
      put_sample(swm_pkg::sample_type'(-100));
      drain();
      write_window(swm_pkg::CSR_W'(2));
      put_sample(swm_pkg::sample_type'(7));
      put_sample(swm_pkg::sample_type'(-7));
      put_sample(swm_pkg::sample_type'(7));
      drain();
   endtask

   // random window settings, clamped ones included, random idling per phase
   task automatic test_random_windows();
      int                        sent;
      int                        phase;
      int                        r;
      int                        n;
      int                        k;
      logic [swm_pkg::CSR_W-1:0] w;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         r = $urandom_range(0, 19);
         if (phase == 0)      w = '1;
         else if (phase == 1) w = swm_pkg::CSR_W'(swm_pkg::WINDOW_MAX);
         else if (r == 0)     w = swm_pkg::CSR_W'(swm_pkg::WINDOW_MAX);
         else if (r == 1)     w = swm_pkg::CSR_W'($urandom_range(swm_pkg::WINDOW_MAX + 1, 127));
         else if (r == 2)     w = '0;
         else if (r < 6)      w = swm_pkg::CSR_W'($urandom_range(10, 40));
         else                 w = swm_pkg::CSR_W'($urandom_range(1, 9));
         write_window(w);
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         // effective length of the window just written
         k = int'(w);
         if (k < 1) k = 1;
         if (k > swm_pkg::WINDOW_MAX) k = swm_pkg::WINDOW_MAX;
         n = k + $urandom_range(5, 40);
         repeat (n) put_sample(pick_sample());
         sent += n;
         drain();
         phase++;
      end
   endtask

   // receiver holds off while the sender keeps offering words back to back
   task automatic test_backpressure();
      write_window(swm_pkg::CSR_W'(2));
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (60) put_sample(pick_sample());
      drain();
      rx_steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_window();
      test_zero_window();
      test_refill();
      test_random_windows();
      test_backpressure();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (medians_due.size() != 0)
         report_mismatch($sformatf("%0d medians never arrived", medians_due.size()));
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
